// ===== hdl/kslc_pkg.sv =====
// Shared types, scancode codes, action codes and the key table for the
// set-1 scancode line decoder. No dependencies.
package kslc_pkg;

	localparam int LINE_LENGTH_DEF    = 128;
	localparam int TERMINAL_COUNT_DEF = 3;

	localparam int SC_W     = 8;
	localparam int ACTION_W = 3;
	localparam int CHAR_W   = 8;
	localparam int COUNT_W  = 3;
	localparam int TERM_W   = 2;
	localparam int POS_W    = 7;
	localparam int LPOS_W   = 8;

	// Scancodes
	localparam logic [SC_W-1:0] SC_CAPS      = 8'h3A;
	localparam logic [SC_W-1:0] SC_LSHIFT    = 8'h2A;
	localparam logic [SC_W-1:0] SC_LSHIFT_UP = 8'hAA;
	localparam logic [SC_W-1:0] SC_RSHIFT    = 8'h36;
	localparam logic [SC_W-1:0] SC_RSHIFT_UP = 8'hB6;
	localparam logic [SC_W-1:0] SC_CTRL      = 8'h1D;
	localparam logic [SC_W-1:0] SC_CTRL_UP   = 8'h9D;
	localparam logic [SC_W-1:0] SC_ALT       = 8'h38;
	localparam logic [SC_W-1:0] SC_ALT_UP    = 8'hB8;
	localparam logic [SC_W-1:0] SC_SPACE     = 8'h39;
	localparam logic [SC_W-1:0] SC_TAB       = 8'h0F;
	localparam logic [SC_W-1:0] SC_BKSP      = 8'h0E;
	localparam logic [SC_W-1:0] SC_ENTER     = 8'h1C;
	localparam logic [SC_W-1:0] SC_F1        = 8'h3B;
	localparam logic [SC_W-1:0] SC_F2        = 8'h3C;
	localparam logic [SC_W-1:0] SC_F3        = 8'h3D;
	localparam logic [SC_W-1:0] KEY_FIRST    = 8'h02;
	localparam logic [SC_W-1:0] KEY_LAST     = 8'h35;

	localparam logic [SC_W-1:0] LETTER_ROW0_LO = 8'h10;
	localparam logic [SC_W-1:0] LETTER_ROW0_HI = 8'h19;
	localparam logic [SC_W-1:0] LETTER_ROW1_LO = 8'h1E;
	localparam logic [SC_W-1:0] LETTER_ROW1_HI = 8'h26;
	localparam logic [SC_W-1:0] LETTER_ROW2_LO = 8'h2C;
	localparam logic [SC_W-1:0] LETTER_ROW2_HI = 8'h32;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_NONE   = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_CHAR   = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_SPACES = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_ERASE  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_EOL    = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_SWITCH = 3'd6;
	localparam logic [ACTION_W-1:0] ACT_FULL   = 3'd7;

	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_L_LOWER = 8'h6C;
	localparam logic [CHAR_W-1:0] CH_L_UPPER = 8'h4C;

	localparam int KEY_HALF   = 52;
	localparam int KEY_ENTRIES = 2 * KEY_HALF;
	localparam int KIDX_W     = 7;
	localparam logic [COUNT_W-1:0] TAB_MAX = 3'd4;

	localparam logic [CHAR_W-1:0] KEYMAP [KEY_ENTRIES] = '{
		8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
		8'h2D, 8'h3D, 8'h20, 8'h20,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70,
		8'h5B, 8'h5D, 8'h20, 8'h20,
		8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
		8'h27, 8'h60, 8'h20, 8'h5C,
		8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F,
		8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29,
		8'h5F, 8'h2B, 8'h20, 8'h20,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50,
		8'h7B, 8'h7D, 8'h20, 8'h20,
		8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
		8'h22, 8'h7E, 8'h20, 8'h7C,
		8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F
	};

	typedef struct packed {
		logic lshift;
		logic rshift;
		logic ctrl;
		logic alt;
		logic caps;
	} kslc_flags_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [CHAR_W-1:0]   character;
		logic [COUNT_W-1:0]  count;
		logic [TERM_W-1:0]   terminal;
		logic [POS_W-1:0]    position;
	} kslc_result_t;

	typedef struct packed {
		kslc_flags_t         flags;
		logic                term_we;
		logic [TERM_W-1:0]   term;
		logic [LPOS_W-1:0]   line_pos;
		logic [LPOS_W-1:0]   floor_pos;
	} kslc_update_t;

	function automatic logic [CHAR_W-1:0] keymap_lookup(input logic [KIDX_W-1:0] idx);
		logic [CHAR_W-1:0] ch;
		ch = '0;
		if (int'(idx) < KEY_ENTRIES)
			ch = KEYMAP[idx];
		return ch;
	endfunction

	function automatic logic is_letter(input logic [SC_W-1:0] sc);
		return (sc >= LETTER_ROW0_LO && sc <= LETTER_ROW0_HI) ||
		       (sc >= LETTER_ROW1_LO && sc <= LETTER_ROW1_HI) ||
		       (sc >= LETTER_ROW2_LO && sc <= LETTER_ROW2_HI);
	endfunction

endpackage

// ===== hdl/keyboard_scancode_line_decoder.sv =====
// Top level of the set-1 scancode line decoder: input register, state
// registers, result register. Depends on kslc_pkg and kslc_decode.
//
// Usage:
//   Scancode channel: scancode_valid / scancode_stall / scancode. One word is
//   taken at each rising edge with scancode_valid high and scancode_stall low.
//   Result channel: result_valid / result_stall with action, character,
//   count, terminal and position. Exactly one result word per scancode word,
//   in order.
//   Path: a scancode taken lands in the input register; its result is
//   registered as it moves on to the result register, and shown until taken.
//   Throughput: one scancode per cycle while the receiver does not stall,
//   with the single decode stage between the input and result registers.
//   Modifier flags, active terminal and per-terminal line position and erase
//   floor update at the edge where a word moves into the result register.
//   Reset (arst_n low, asynchronous): all flags, the active terminal and all
//   positions and floors go to zero; both register stages empty.
//   Receiver stall: the result holds; the input register keeps taking a word
//   until it is full, then scancode_stall rises.
module keyboard_scancode_line_decoder #(
	parameter int LINE_LENGTH    = kslc_pkg::LINE_LENGTH_DEF,
	parameter int TERMINAL_COUNT = kslc_pkg::TERMINAL_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          scancode_valid,
	output logic                          scancode_stall,
	input  logic [kslc_pkg::SC_W-1:0]     scancode,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [kslc_pkg::ACTION_W-1:0] action,
	output logic [kslc_pkg::CHAR_W-1:0]   character,
	output logic [kslc_pkg::COUNT_W-1:0]  count,
	output logic [kslc_pkg::TERM_W-1:0]   terminal,
	output logic [kslc_pkg::POS_W-1:0]    position
);
	import kslc_pkg::*;

	localparam int TIDX_W = (TERMINAL_COUNT > 1) ? $clog2(TERMINAL_COUNT) : 1;
	localparam logic [TERM_W-1:0] TC = TERM_W'(TERMINAL_COUNT);

	logic                sc_valid_s1;
	logic [SC_W-1:0]     sc_s1;
	logic                res_valid_s2;
	kslc_result_t        res_s2;

	kslc_flags_t         flags_q;
	logic [TERM_W-1:0]   active_q;
	logic [LPOS_W-1:0]   line_pos_q  [TERMINAL_COUNT];
	logic [LPOS_W-1:0]   floor_pos_q [TERMINAL_COUNT];

	logic                advance;
	logic [TERM_W-1:0]   term_cur;
	logic [TIDX_W-1:0]   t_idx;
	kslc_result_t        res_d;
	kslc_update_t        upd;

	assign advance        = sc_valid_s1 & (~res_valid_s2 | ~result_stall);
	assign scancode_stall = sc_valid_s1 & ~advance;

	// an out-of-range terminal value acts as terminal zero
	assign term_cur = (active_q < TC) ? active_q : '0;
	assign t_idx    = term_cur[TIDX_W-1:0];

	kslc_decode #(
		.LINE_LENGTH    (LINE_LENGTH),
		.TERMINAL_COUNT (TERMINAL_COUNT)
	) u_decode (
		.scancode  (sc_s1),
		.flags     (flags_q),
		.term      (term_cur),
		.line_pos  (line_pos_q[t_idx]),
		.floor_pos (floor_pos_q[t_idx]),
		.res       (res_d),
		.upd       (upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_valid_s1 <= 1'b0;
		end else if (!scancode_stall) begin
			sc_valid_s1 <= scancode_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!scancode_stall && scancode_valid) begin
			sc_s1 <= scancode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q  <= '0;
			active_q <= '0;
			for (int i = 0; i < TERMINAL_COUNT; i++) begin
				line_pos_q[i]  <= '0;
				floor_pos_q[i] <= '0;
			end
		end else if (advance) begin
			flags_q                <= upd.flags;
			line_pos_q[t_idx]      <= upd.line_pos;
			floor_pos_q[t_idx]     <= upd.floor_pos;
			if (upd.term_we) begin
				active_q <= upd.term;
			end
		end
	end

	assign result_valid = res_valid_s2;
	assign action       = res_s2.action;
	assign character    = res_s2.character;
	assign count        = res_s2.count;
	assign terminal     = res_s2.terminal;
	assign position     = res_s2.position;

`ifndef NO_ASSERTIONS
	a_term_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q < TC)
		else $error("active terminal out of range");

	a_pos_limit: assert property (@(posedge clk) disable iff (!arst_n)
		line_pos_q[t_idx] <= LPOS_W'(LINE_LENGTH))
		else $error("line position past line length");

	a_floor_below_pos: assert property (@(posedge clk) disable iff (!arst_n)
		floor_pos_q[t_idx] <= line_pos_q[t_idx])
		else $error("erase floor above line position");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_s2)
		else $error("decoded word lost");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 |-> res_s2.count <= TAB_MAX)
		else $error("result count above four");
`endif

endmodule

// ===== hdl/kslc_decode.sv =====
// Combinational decode of one scancode against the current modifier and line
// state: gives the result word and the next state. Depends on kslc_pkg.
module kslc_decode #(
	parameter int LINE_LENGTH    = kslc_pkg::LINE_LENGTH_DEF,
	parameter int TERMINAL_COUNT = kslc_pkg::TERMINAL_COUNT_DEF
) (
	input  logic [kslc_pkg::SC_W-1:0]   scancode,
	input  kslc_pkg::kslc_flags_t       flags,
	input  logic [kslc_pkg::TERM_W-1:0] term,
	input  logic [kslc_pkg::LPOS_W-1:0] line_pos,
	input  logic [kslc_pkg::LPOS_W-1:0] floor_pos,
	output kslc_pkg::kslc_result_t      res,
	output kslc_pkg::kslc_update_t      upd
);
	import kslc_pkg::*;

	localparam logic [LPOS_W-1:0] LL = LPOS_W'(LINE_LENGTH);
	localparam logic [TERM_W-1:0] TC = TERM_W'(TERMINAL_COUNT);

	logic                pos_ok;
	logic [LPOS_W-1:0]   room;
	logic [COUNT_W-1:0]  tab_n;
	logic [TERM_W-1:0]   sw_n;
	logic                shifted;
	logic [KIDX_W-1:0]   kidx;
	logic [CHAR_W-1:0]   ch;

	assign pos_ok = line_pos < LL;
	assign room   = LL - line_pos;
	assign tab_n  = (room >= LPOS_W'(TAB_MAX)) ? TAB_MAX : room[COUNT_W-1:0];
	assign sw_n   = TERM_W'(scancode - SC_F1);

	// caps flips case on letters only
	assign shifted = (flags.lshift | flags.rshift) ^ (flags.caps & is_letter(scancode));
	assign kidx    = KIDX_W'(scancode - KEY_FIRST) + (shifted ? KIDX_W'(KEY_HALF) : '0);
	assign ch      = keymap_lookup(kidx);

	always_comb begin
		res           = '{ACT_NONE, '0, '0, term, '0};
		upd.flags     = flags;
		upd.term_we   = 1'b0;
		upd.term      = term;
		upd.line_pos  = line_pos;
		upd.floor_pos = floor_pos;
		case (scancode)
			SC_CAPS:      upd.flags.caps   = ~flags.caps;
			SC_LSHIFT:    upd.flags.lshift = 1'b1;
			SC_LSHIFT_UP: upd.flags.lshift = 1'b0;
			SC_RSHIFT:    upd.flags.rshift = 1'b1;
			SC_RSHIFT_UP: upd.flags.rshift = 1'b0;
			SC_CTRL:      upd.flags.ctrl   = 1'b1;
			SC_CTRL_UP:   upd.flags.ctrl   = 1'b0;
			SC_ALT:       upd.flags.alt    = 1'b1;
			SC_ALT_UP:    upd.flags.alt    = 1'b0;
			SC_SPACE: begin
				if (pos_ok) begin
					upd.line_pos = line_pos + LPOS_W'(1);
					res = '{ACT_CHAR, CH_SPACE, COUNT_W'(1), term, line_pos[POS_W-1:0]};
				end else begin
					res = '{ACT_FULL, '0, '0, term, line_pos[POS_W-1:0]};
				end
			end
			SC_TAB: begin
				if (pos_ok) begin
					upd.line_pos = line_pos + LPOS_W'(tab_n);
					res = '{ACT_SPACES, CH_SPACE, tab_n, term, line_pos[POS_W-1:0]};
				end else begin
					res = '{ACT_FULL, '0, '0, term, line_pos[POS_W-1:0]};
				end
			end
			SC_BKSP: begin
				if (line_pos > floor_pos) begin
					upd.line_pos = line_pos - LPOS_W'(1);
					res = '{ACT_ERASE, '0, COUNT_W'(1), term, upd.line_pos[POS_W-1:0]};
				end
			end
			SC_ENTER: begin
				res = '{ACT_EOL, CH_NEWLINE, COUNT_W'(pos_ok), term, line_pos[POS_W-1:0]};
				upd.line_pos  = '0;
				upd.floor_pos = '0;
			end
			SC_F1, SC_F2, SC_F3: begin
				if (flags.alt && sw_n < TC && sw_n != term) begin
					upd.term_we = 1'b1;
					upd.term    = sw_n;
					res = '{ACT_SWITCH, '0, '0, sw_n, '0};
				end
			end
			default: begin
				if (scancode >= KEY_FIRST && scancode <= KEY_LAST) begin
					if (flags.ctrl && (ch == CH_L_LOWER || ch == CH_L_UPPER)) begin
						// floor moves up to the cursor; at zero both stay zero
						upd.floor_pos = line_pos;
						res = '{ACT_CLEAR, '0, '0, term, line_pos[POS_W-1:0]};
					end else if (pos_ok) begin
						upd.line_pos = line_pos + LPOS_W'(1);
						res = '{ACT_CHAR, ch, COUNT_W'(1), term, line_pos[POS_W-1:0]};
					end else begin
						res = '{ACT_FULL, '0, '0, term, line_pos[POS_W-1:0]};
					end
				end
			end
		endcase
	end

endmodule

// ===== tb/kslc_line_checker.sv =====
// Scoreboard for the set-1 scancode line decoder: predicts one result word per
// accepted scancode word and compares it with the block's output.
// Depends on kslc_pkg for widths, codes and the result type.
`timescale 1ns / 100ps

module kslc_line_checker #(
	parameter int LINE_LENGTH    = kslc_pkg::LINE_LENGTH_DEF,
	parameter int TERMINAL_COUNT = kslc_pkg::TERMINAL_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          scancode_valid,
	input  logic                          scancode_stall,
	input  logic [kslc_pkg::SC_W-1:0]     scancode,
	input  logic                          result_valid,
	input  logic                          result_stall,
	input  logic [kslc_pkg::ACTION_W-1:0] action,
	input  logic [kslc_pkg::CHAR_W-1:0]   character,
	input  logic [kslc_pkg::COUNT_W-1:0]  count,
	input  logic [kslc_pkg::TERM_W-1:0]   terminal,
	input  logic [kslc_pkg::POS_W-1:0]    position,
	output int                            failures,
	output int                            pending,
	output int                            checked,
	output logic [7:0]                    action_mask
);
	import kslc_pkg::*;

	// Key table, unshifted and shifted halves, first key at the top byte.
	localparam bit [KEY_HALF*8-1:0] PLAIN_KEYS =
		{"1234567890-=  ", "qwertyuiop[]  ", "asdfghjkl;'` \\", "zxcvbnm,./"};
	localparam bit [KEY_HALF*8-1:0] SHIFT_KEYS =
		{"!@#$%^&*()_+  ", "QWERTYUIOP{}  ", "ASDFGHJKL:\"~ |", "ZXCVBNM<>?"};

	logic              lshift_down, rshift_down, ctrl_down, alt_down, caps_active;
	logic [TERM_W-1:0] model_term;
	logic [LPOS_W-1:0] line_pos [TERMINAL_COUNT];
	logic [LPOS_W-1:0] floor_pos [TERMINAL_COUNT];

	kslc_result_t expected_results [$];
	kslc_result_t predicted, oldest;

	task automatic report_failure(input string msg);
		$display("[%0t] result %0d: %s", $realtime, checked, msg);
		failures = failures + 1;
	endtask

	task automatic clear_state();
		lshift_down = 1'b0;
		rshift_down = 1'b0;
		ctrl_down   = 1'b0;
		alt_down    = 1'b0;
		caps_active = 1'b0;
		model_term  = '0;
		for (int i = 0; i < TERMINAL_COUNT; i++) begin
			line_pos[i]  = '0;
			floor_pos[i] = '0;
		end
	endtask

	// Work out the result word for one scancode and advance the line state.
	task automatic decode_scancode(input logic [SC_W-1:0] sc, output kslc_result_t res);
		int t, pos, room, n, idx;
		logic shifted, letter;
		logic [CHAR_W-1:0] ch;
		t   = (int'(model_term) >= TERMINAL_COUNT) ? 0 : int'(model_term);
		pos = int'(line_pos[t]);
		res = '0;
		res.terminal = TERM_W'(t);
		case (sc)
			SC_CAPS:      caps_active = !caps_active;
			SC_LSHIFT:    lshift_down = 1'b1;
			SC_LSHIFT_UP: lshift_down = 1'b0;
			SC_RSHIFT:    rshift_down = 1'b1;
			SC_RSHIFT_UP: rshift_down = 1'b0;
			SC_CTRL:      ctrl_down = 1'b1;
			SC_CTRL_UP:   ctrl_down = 1'b0;
			SC_ALT:       alt_down = 1'b1;
			SC_ALT_UP:    alt_down = 1'b0;
			SC_SPACE: begin
				if (pos < LINE_LENGTH) begin
					line_pos[t]   = LPOS_W'(pos + 1);
					res.action    = ACT_CHAR;
					res.character = CH_SPACE;
					res.count     = COUNT_W'(1);
				end else begin
					res.action = ACT_FULL;
				end
				res.position = POS_W'(pos);
			end
			SC_TAB: begin
				room = (pos < LINE_LENGTH) ? LINE_LENGTH - pos : 0;
				n    = (room < int'(TAB_MAX)) ? room : int'(TAB_MAX);
				if (n == 0) begin
					res.action = ACT_FULL;
				end else begin
					line_pos[t]   = LPOS_W'(pos + n);
					res.action    = ACT_SPACES;
					res.character = CH_SPACE;
					res.count     = COUNT_W'(n);
				end
				res.position = POS_W'(pos);
			end
			SC_BKSP: begin
				// drop nothing at or below the erase floor
				if (pos > int'(floor_pos[t])) begin
					line_pos[t]  = LPOS_W'(pos - 1);
					res.action   = ACT_ERASE;
					res.count    = COUNT_W'(1);
					res.position = POS_W'(pos - 1);
				end
			end
			SC_ENTER: begin
				res.action    = ACT_EOL;
				res.character = CH_NEWLINE;
				res.count     = (pos < LINE_LENGTH) ? COUNT_W'(1) : COUNT_W'(0);
				res.position  = POS_W'(pos);
				line_pos[t]   = '0;
				floor_pos[t]  = '0;
			end
			SC_F1, SC_F2, SC_F3: begin
				n = int'(sc - SC_F1);
				if (alt_down && n < TERMINAL_COUNT && n != t) begin
					model_term   = TERM_W'(n);
					res.action   = ACT_SWITCH;
					res.terminal = TERM_W'(n);
				end
			end
			default: begin
				if (sc >= KEY_FIRST && sc <= KEY_LAST) begin
					idx     = int'(sc - KEY_FIRST);
					shifted = lshift_down || rshift_down;
					letter  = (sc >= LETTER_ROW0_LO && sc <= LETTER_ROW0_HI) ||
					          (sc >= LETTER_ROW1_LO && sc <= LETTER_ROW1_HI) ||
					          (sc >= LETTER_ROW2_LO && sc <= LETTER_ROW2_HI);
					if (caps_active && letter)
						shifted = !shifted;
					ch = shifted ? SHIFT_KEYS[8*(KEY_HALF-1-idx) +: 8]
					             : PLAIN_KEYS[8*(KEY_HALF-1-idx) +: 8];
					if (ctrl_down && (ch == CH_L_LOWER || ch == CH_L_UPPER)) begin
						if (pos != 0) begin
							floor_pos[t] = LPOS_W'(pos);
						end else begin
							line_pos[t]  = '0;
							floor_pos[t] = '0;
						end
						res.action   = ACT_CLEAR;
						res.position = POS_W'(floor_pos[t]);
					end else if (pos < LINE_LENGTH) begin
						line_pos[t]   = LPOS_W'(pos + 1);
						res.action    = ACT_CHAR;
						res.character = ch;
						res.count     = COUNT_W'(1);
						res.position  = POS_W'(pos);
					end else begin
						res.action   = ACT_FULL;
						res.position = POS_W'(pos);
					end
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			expected_results.delete();
			failures = 0;
			pending     <= 0;
			checked     <= 0;
			action_mask <= '0;
		end else begin
			if (scancode_valid && !scancode_stall) begin
				decode_scancode(scancode, predicted);
				expected_results.push_back(predicted);
			end
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					report_failure("result word with nothing expected");
				end else begin
					oldest = expected_results.pop_front();
					if (action !== oldest.action)
						report_failure($sformatf("action %0d, expected %0d",
							action, oldest.action));
					if (character !== oldest.character)
						report_failure($sformatf("character %h, expected %h",
							character, oldest.character));
					if (count !== oldest.count)
						report_failure($sformatf("count %0d, expected %0d",
							count, oldest.count));
					if (terminal !== oldest.terminal)
						report_failure($sformatf("terminal %0d, expected %0d",
							terminal, oldest.terminal));
					if (position !== oldest.position)
						report_failure($sformatf("position %0d, expected %0d",
							position, oldest.position));
				end
				checked <= checked + 1;
				action_mask[action] <= 1'b1;
			end
			pending <= expected_results.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Top of the scancode line decoder testbench: clock, reset, scancode stimulus,
// result-side stalls and the verdict. Depends on kslc_pkg, kslc_line_checker
// and keyboard_scancode_line_decoder.
`timescale 1ns / 100ps

module tb_top;
	import kslc_pkg::*;

	localparam int RANDOM_WORDS = 1950;
	localparam int CYCLE_LIMIT  = 300000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                scancode_valid = 1'b0;
	logic                scancode_stall;
	logic [SC_W-1:0]     scancode = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	logic [ACTION_W-1:0] action;
	logic [CHAR_W-1:0]   character;
	logic [COUNT_W-1:0]  count;
	logic [TERM_W-1:0]   terminal;
	logic [POS_W-1:0]    position;

	int         failures, pending, checked;
	logic [7:0] action_mask;
	int         cycles = 0;
	int         words_sent = 0;
	int         drains = 0;
	bit         tx_quiet = 1'b0;
	bit         rx_quiet = 1'b0;
	int         rx_hold = 0;

	logic [SC_W-1:0] directed_words [$];

	keyboard_scancode_line_decoder dut (
		.clk(clk), .arst_n(arst_n),
		.scancode_valid(scancode_valid), .scancode_stall(scancode_stall),
		.scancode(scancode),
		.result_valid(result_valid), .result_stall(result_stall),
		.action(action), .character(character), .count(count),
		.terminal(terminal), .position(position)
	);

	kslc_line_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.scancode_valid(scancode_valid), .scancode_stall(scancode_stall),
		.scancode(scancode),
		.result_valid(result_valid), .result_stall(result_stall),
		.action(action), .character(character), .count(count),
		.terminal(terminal), .position(position),
		.failures(failures), .pending(pending), .checked(checked),
		.action_mask(action_mask)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		cycles <= cycles + 1;

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results still expected", cycles, pending);
		$display("simulation failed");
		$finish;
	end

	// Result side: hold stall for a drawn number of cycles before each word.
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			result_stall <= 1'b1;
			rx_hold = rx_hold - 1;
		end else begin
			result_stall <= 1'b0;
			if (result_valid) begin
				if ($urandom_range(0, 63) == 0)
					rx_quiet = !rx_quiet;
				rx_hold = rx_quiet ? 0 : $urandom_range(0, 10);
			end
		end
	end

	function automatic int draw_gap();
		if ($urandom_range(0, 99) == 0)
			tx_quiet = !tx_quiet;
		return tx_quiet ? 0 : $urandom_range(0, 10);
	endfunction

	task automatic send_word(input logic [SC_W-1:0] sc, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			scancode_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		scancode_valid <= 1'b1;
		scancode       <= sc;
		@(posedge clk);
		while (scancode_stall)
			@(posedge clk);
		words_sent++;
	endtask

	// Hold off the sender until every expected result is in.
	task automatic drain();
		@(negedge clk);
		scancode_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		drains++;
	endtask

	// Mostly typing with line edits; long lines skip enter so they fill up.
	function automatic logic [SC_W-1:0] pick_word(input bit long_line);
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return SC_W'($urandom_range(int'(KEY_FIRST), int'(KEY_LAST)));
		if (r < 63)
			return SC_SPACE;
		if (r < 70)
			return SC_TAB;
		if (r < 77)
			return SC_BKSP;
		if (r < 85) begin
			case ($urandom_range(0, 8))
				0: return SC_LSHIFT;
				1: return SC_LSHIFT_UP;
				2: return SC_RSHIFT;
				3: return SC_RSHIFT_UP;
				4: return SC_CTRL;
				5: return SC_CTRL_UP;
				6: return SC_ALT;
				7: return SC_ALT_UP;
				default: return SC_CAPS;
			endcase
		end
		if (r < 89)
			return SC_W'($urandom_range(int'(SC_F1), int'(SC_F3)));
		if (r < 92)
			return 8'h26;
		if (r < 94 && !long_line)
			return SC_ENTER;
		return SC_W'($urandom_range(0, 255));
	endfunction

	initial begin
		int  line_words;
		bit  long_line;
		int  next_drain;
		directed_words = '{
			SC_F1, SC_BKSP, 8'h00, 8'hFF, 8'h01, 8'h37, 8'h3E, 8'h90,
			8'h10, SC_CAPS, 8'h10, SC_LSHIFT, 8'h10, KEY_FIRST, SC_LSHIFT_UP,
			KEY_LAST, SC_CTRL, 8'h26, SC_BKSP, SC_SPACE, SC_TAB, SC_BKSP,
			SC_ENTER, 8'h26, SC_CTRL_UP
		};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_words[i])
			send_word(directed_words[i], draw_gap());
		// terminal switching: same terminal, new terminal and back
		send_word(SC_ALT, draw_gap());
		send_word(SC_F1, draw_gap());
		send_word(SC_F3, draw_gap());
		send_word(SC_F1, draw_gap());
		send_word(SC_ALT_UP, draw_gap());
		drain();

		next_drain = words_sent + 600;
		while (words_sent < RANDOM_WORDS + directed_words.size() + 5) begin
			long_line  = ($urandom_range(0, 9) < 3);
			line_words = long_line ? $urandom_range(160, 260) : $urandom_range(1, 40);
			repeat (line_words)
				send_word(pick_word(long_line), draw_gap());
			send_word(SC_ENTER, draw_gap());
			if (words_sent >= next_drain) begin
				drain();
				next_drain = words_sent + 600;
			end
		end

		@(negedge clk);
		scancode_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);

		$display("%0d scancode words sent, %0d result words checked, %0d full drains",
			words_sent, checked, drains);
		$display("action codes seen (bit n for code n): %b", action_mask);
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
